// ===== rtl/base58_encoder_top_defines.svh =====
// Assertion macros shared by the base58 encoder RTL.
`ifndef BASE58_ENCODER_TOP_DEFINES_SVH
`define BASE58_ENCODER_TOP_DEFINES_SVH

// Checks that cons holds in the same cycle as ante.
`define B58E_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that cons holds in the cycle after ante.
`define B58E_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/b58e_pkg.sv =====
// Package with constants and the alphabet lookup for the base58 encoder.
`timescale 1ns / 1ps

package b58e_pkg;

    localparam int B58E_DIGITS = 34;
    localparam int B58E_DIGIT_W = 6;
    localparam int B58E_BYTE_W = 8;
    localparam int B58E_CHAR_W = 7;
    localparam int B58E_ACC_W = B58E_DIGIT_W + B58E_BYTE_W;
    localparam int B58E_RECIP_SHIFT = 17;
    localparam logic [11:0] B58E_RECIP = 12'd2260;

    function automatic logic [B58E_CHAR_W-1:0] b58e_char(input logic [B58E_DIGIT_W-1:0] d);
        logic [B58E_CHAR_W-1:0] dv;
        logic [B58E_CHAR_W-1:0] ch;
        dv = {1'b0, d};
        if (d <= 6'd8)
        begin
            ch = 7'd49 + dv;
        end
        else if (d <= 6'd16)
        begin
            ch = 7'd65 + dv - 7'd9;
        end
        else if (d <= 6'd21)
        begin
            ch = 7'd74 + dv - 7'd17;
        end
        else if (d <= 6'd32)
        begin
            ch = 7'd80 + dv - 7'd22;
        end
        else if (d <= 6'd43)
        begin
            ch = 7'd97 + dv - 7'd33;
        end
        else if (d <= 6'd57)
        begin
            ch = 7'd109 + dv - 7'd44;
        end
        else
        begin
            ch = 7'd49;
        end
        return ch;
    endfunction

endpackage

// ===== rtl/base58_encoder_top.sv =====
// Base58 encoder: byte stream in, Bitcoin-alphabet character stream out.
// Each byte is accepted while idle, then the store rotates digit by digit
// through one shared multiply-by-256 and divide-by-58 unit.
// On a last byte, the digit pass is followed by the character string, which
// stalls on m_axis_tready; no new byte is taken until the string is done.
// Reset clears the digit store and returns the block to idle at once.
`timescale 1ns / 1ps
`include "base58_encoder_top_defines.svh"

module base58_encoder_top #(
    parameter int OUT_DIGITS = b58e_pkg::B58E_DIGITS
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [6:0] out_char, [7] zero
    output logic       m_axis_tlast
);

    localparam int DW = b58e_pkg::B58E_DIGIT_W;
    localparam int BW = b58e_pkg::B58E_BYTE_W;
    localparam int AW = b58e_pkg::B58E_ACC_W;
    localparam int PW = AW + 12;
    localparam int SH = b58e_pkg::B58E_RECIP_SHIFT;
    localparam int CW = (OUT_DIGITS > 1) ? $clog2(OUT_DIGITS) : 1;
    localparam logic [CW-1:0] CNT_END = CW'(OUT_DIGITS - 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CALC = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t        state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [BW-1:0] carry_reg, carry_next;
    logic          last_reg, last_next;
    logic [DW-1:0] dig_reg [OUT_DIGITS];

    logic [AW-1:0] acc;
    logic [PW-1:0] prod;
    logic [BW-1:0] quot;
    logic [AW-1:0] quot58;
    logic [AW-1:0] rem_full;
    logic [DW-1:0] new_digit;
    logic          in_req;
    logic          out_req;
    logic          cnt_done;

    // Digit 0 of the store is the one under update; the store rotates so the
    // least significant digit comes first and returns there after a full pass.
    assign acc = {dig_reg[0], carry_reg};
    assign prod = PW'(acc) * PW'(b58e_pkg::B58E_RECIP);
    assign quot = prod[SH+BW-1:SH];
    assign quot58 = (AW'(quot) << 6) - (AW'(quot) << 2) - (AW'(quot) << 1);
    assign rem_full = acc - quot58;
    assign new_digit = rem_full[DW-1:0];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = (state_reg == ST_EMIT);
    assign m_axis_tdata = {1'b0, b58e_pkg::b58e_char(dig_reg[OUT_DIGITS-1])};
    assign m_axis_tlast = cnt_done;

    assign in_req = s_axis_tvalid && s_axis_tready;
    assign out_req = m_axis_tvalid && m_axis_tready;
    assign cnt_done = (cnt_reg == CNT_END);

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        carry_next = carry_reg;
        last_next = last_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_req)
                begin
                    carry_next = s_axis_tdata;
                    last_next = s_axis_tlast;
                    cnt_next = '0;
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                carry_next = quot;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_done)
                begin
                    cnt_next = '0;
                    state_next = last_reg ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (out_req)
                begin
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_done)
                    begin
                        cnt_next = '0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                cnt_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg <= '0;
            carry_reg <= '0;
            last_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            carry_reg <= carry_next;
            last_reg <= last_next;
        end
    end

    // During an update the store rotates toward digit 0; while emitting it
    // shifts the other way, presenting the most significant digit and
    // filling with zeros so the store is clear when the string ends.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < OUT_DIGITS; i++)
            begin
                dig_reg[i] <= '0;
            end
        end
        else if (state_reg == ST_CALC)
        begin
            for (int i = 0; i < OUT_DIGITS - 1; i++)
            begin
                dig_reg[i] <= dig_reg[i+1];
            end
            dig_reg[OUT_DIGITS-1] <= new_digit;
        end
        else if (out_req)
        begin
            for (int i = 1; i < OUT_DIGITS; i++)
            begin
                dig_reg[i] <= dig_reg[i-1];
            end
            dig_reg[0] <= '0;
        end
    end

    `B58E_ASSERT_SAME(a_one_side, s_axis_tready, !m_axis_tvalid, "input and output both open")
    `B58E_ASSERT_NEXT(a_start_pass, in_req, (state_reg == ST_CALC) && (cnt_reg == '0),
                      "accepted byte did not start a digit pass")
    `B58E_ASSERT_NEXT(a_end_string, out_req && m_axis_tlast, s_axis_tready,
                      "block not idle after final character")
    `B58E_ASSERT_SAME(a_digit_range, m_axis_tvalid, dig_reg[OUT_DIGITS-1] <= 6'd57,
                      "digit out of base58 range")

endmodule
